### rtl/depth_pixel_backprojection_assert.svh
// Assertion macros used by the checker of this block.
`ifndef DEPTH_PIXEL_BACKPROJECTION_ASSERT_SVH
`define DEPTH_PIXEL_BACKPROJECTION_ASSERT_SVH

// Consequent checked in the same cycle.
`define DPB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dpb assertion failed");

// Consequent checked in the cycle after the antecedent.
`define DPB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dpb assertion failed");

`endif

### rtl/dpb_pkg.sv
`timescale 1ns / 1ps

package dpb_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 63;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_X       = 3'd0,
    CFG_ROT_Y       = 3'd1,
    CFG_ROT_Z       = 3'd2,
    CFG_TRANSLATION = 3'd3,
    CFG_PRINCIPAL   = 3'd4,
    CFG_INV_FOCAL   = 3'd5,
    CFG_MAX_DEPTH   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [53:0] rot_row_x;
    logic [53:0] rot_row_y;
    logic [53:0] rot_row_z;
    logic [62:0] translation_xyz;
    logic [23:0] principal_point;
    logic [47:0] inverse_focal;
    logic [15:0] max_depth;
  } cfg_t;

  localparam logic [15:0] MAX_DEPTH_RST = 16'd7000;

  localparam cfg_t CFG_RST = '{
    rot_row_x:       54'd4503599627370496,
    rot_row_y:       54'd17179869184,
    rot_row_z:       54'd65536,
    translation_xyz: 63'd0,
    principal_point: 24'd2667003,
    inverse_focal:   48'd543380504134,
    max_depth:       MAX_DEPTH_RST
  };

  typedef struct packed {
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
    logic [15:0] raw_depth;
  } pix_t;

  typedef struct packed {
    logic signed [23:0] world_x;
    logic signed [23:0] world_y;
    logic signed [23:0] world_z;
  } point_t;

  // queue entry: offsets from the principal point in half pixels, and depth
  typedef struct packed {
    logic signed [13:0] du;
    logic signed [13:0] dv;
    logic [15:0]        depth;
  } qitem_t;

  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int BACK_STAGES = 6;
  localparam int PEND_MAX    = QDEPTH + BACK_STAGES;
  localparam int PEND_W      = $clog2(PEND_MAX + 1);

endpackage

### rtl/dpb_front.sv
`timescale 1ns / 1ps

module dpb_front (
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  dpb_pkg::pix_t  in_data_i,
  input  dpb_pkg::cfg_t  cfg_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output dpb_pkg::qitem_t q_item_o
);
  import dpb_pkg::*;

  logic keep;

  assign keep = (in_data_i.raw_depth != 16'd0) && (in_data_i.raw_depth < cfg_i.max_depth);

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && keep;

  always_comb begin
    q_item_o.du    = $signed({1'b0, in_data_i.pixel_col, 1'b0})
                   - $signed({2'b00, cfg_i.principal_point[23:12]});
    q_item_o.dv    = $signed({1'b0, in_data_i.pixel_row, 1'b0})
                   - $signed({2'b00, cfg_i.principal_point[11:0]});
    q_item_o.depth = in_data_i.raw_depth;
  end

endmodule

### rtl/dpb_queue.sv
`timescale 1ns / 1ps

module dpb_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dpb_pkg::qitem_t push_data_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output dpb_pkg::qitem_t head_o
);
  import dpb_pkg::*;

  qitem_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/dpb_back.sv
`timescale 1ns / 1ps

module dpb_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dpb_pkg::cfg_t   cfg_i,
  input  logic            q_empty_i,
  input  dpb_pkg::qitem_t q_head_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output dpb_pkg::point_t out_data_o
);
  import dpb_pkg::*;

  function automatic logic [23:0] sat24(input logic signed [33:0] v);
    logic [23:0] r;
    if (v > 34'sd8388607) begin
      r = 24'h7FFFFF;
    end else if (v < -34'sd8388608) begin
      r = 24'h800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  localparam logic signed [53:0] RND17 = 54'sd65536;
  localparam logic signed [56:0] RND24 = 57'sd8388608;

  logic        adv;
  logic [4:0]  vld_q, vld_d;
  logic        out_valid_q;

  logic [53:0] rows [3];
  logic [20:0] trans [3];

  // stage 1: offset times depth
  logic signed [29:0] s1_pxd_q, s1_pyd_q;
  logic [15:0]        s1_d_q;
  // stage 2: times reciprocal focal
  logic signed [53:0] s2_ax_q, s2_ay_q;
  logic [15:0]        s2_d_q;
  // stage 3: camera point, Q.8
  logic signed [53:0] s3_tx, s3_ty;
  logic signed [36:0] s3_camx_q, s3_camy_q;
  logic signed [24:0] s3_camz_q;
  // stage 4: partial products per rotation row
  logic signed [37:0] plx_lo_d [3], plx_lo_q [3];
  logic signed [35:0] plx_hi_d [3], plx_hi_q [3];
  logic signed [37:0] ply_lo_d [3], ply_lo_q [3];
  logic signed [35:0] ply_hi_d [3], ply_hi_q [3];
  logic signed [42:0] pz_d [3], pz_q [3];
  // stage 5: rounded dot products
  logic signed [56:0] acc [3];
  logic signed [32:0] dot_q [3];
  // output register
  point_t             out_q, out_d;

  assign adv         = !(out_valid_q && out_stall_i);
  assign q_pop_o     = adv && !q_empty_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign rows[0]  = cfg_i.rot_row_x;
  assign rows[1]  = cfg_i.rot_row_y;
  assign rows[2]  = cfg_i.rot_row_z;
  assign trans[0] = cfg_i.translation_xyz[62:42];
  assign trans[1] = cfg_i.translation_xyz[41:21];
  assign trans[2] = cfg_i.translation_xyz[20:0];

  assign vld_d = {vld_q[3:0], !q_empty_i};

  assign s3_tx = s2_ax_q + RND17;
  assign s3_ty = s2_ay_q + RND17;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      plx_lo_d[i] = $signed(rows[i][53:36]) * $signed({1'b0, s3_camx_q[18:0]});
      plx_hi_d[i] = $signed(rows[i][53:36]) * $signed(s3_camx_q[36:19]);
      ply_lo_d[i] = $signed(rows[i][35:18]) * $signed({1'b0, s3_camy_q[18:0]});
      ply_hi_d[i] = $signed(rows[i][35:18]) * $signed(s3_camy_q[36:19]);
      pz_d[i]     = $signed(rows[i][17:0]) * s3_camz_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = (57'(plx_hi_q[i]) <<< 19) + 57'(plx_lo_q[i])
             + (57'(ply_hi_q[i]) <<< 19) + 57'(ply_lo_q[i])
             + 57'(pz_q[i]) + RND24;
    end
  end

  always_comb begin
    out_d.world_x = sat24(34'(dot_q[0]) + 34'($signed(trans[0])));
    out_d.world_y = sat24(34'(dot_q[1]) + 34'($signed(trans[1])));
    out_d.world_z = sat24(34'(dot_q[2]) + 34'($signed(trans[2])));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= vld_d;
      out_valid_q <= vld_q[4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pxd_q  <= q_head_i.du * $signed({1'b0, q_head_i.depth});
      s1_pyd_q  <= q_head_i.dv * $signed({1'b0, q_head_i.depth});
      s1_d_q    <= q_head_i.depth;
      s2_ax_q   <= s1_pxd_q * $signed({1'b0, cfg_i.inverse_focal[47:24]});
      s2_ay_q   <= s1_pyd_q * $signed({1'b0, cfg_i.inverse_focal[23:0]});
      s2_d_q    <= s1_d_q;
      s3_camx_q <= s3_tx[53:17];
      s3_camy_q <= s3_ty[53:17];
      s3_camz_q <= $signed({1'b0, s2_d_q, 8'h00});
      for (int i = 0; i < 3; i++) begin
        plx_lo_q[i] <= plx_lo_d[i];
        plx_hi_q[i] <= plx_hi_d[i];
        ply_lo_q[i] <= ply_lo_d[i];
        ply_hi_q[i] <= ply_hi_d[i];
        pz_q[i]     <= pz_d[i];
        dot_q[i]    <= acc[i][56:24];
      end
      out_q <= out_d;
    end
  end

endmodule

### rtl/depth_pixel_backprojection.sv
`timescale 1ns / 1ps

// Depth pixel to world point. Input channel: in_valid_i/in_stall_o with one
// pixel item (column, row, raw depth). Output channel: out_valid_o/out_stall_i
// with one world point item (x, y, z, 24-bit signed, saturated).
// A pixel whose depth is zero or at or above max_depth yields no item.
// Configuration: write cfg_wdata_i to register cfg_idx_i when cfg_we_i is high;
// the user must change registers only while no item is in flight; the block
// itself does not enforce this. A kept pixel goes through the pixel queue and
// then the six-stage back pipeline, whose last stage is the output register.
// Throughput: one item per cycle, in and out, while the output is not stalled.
// A stalled output freezes the back pipeline; the front keeps accepting until
// the 4-entry pixel queue fills, then raises in_stall_o.
// Reset clears the queue and pipeline valids and loads the register defaults
// (identity rotation, zero translation, 640x480 style intrinsics, max 7000).
module depth_pixel_backprojection (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  dpb_pkg::pix_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output dpb_pkg::point_t                  out_data_o
);
  import dpb_pkg::*;

  cfg_t   cfg_q, cfg_d;
  logic   q_full, q_empty, q_push, q_pop;
  qitem_t q_item, q_head;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROT_X:       cfg_d.rot_row_x       = cfg_wdata_i[53:0];
        CFG_ROT_Y:       cfg_d.rot_row_y       = cfg_wdata_i[53:0];
        CFG_ROT_Z:       cfg_d.rot_row_z       = cfg_wdata_i[53:0];
        CFG_TRANSLATION: cfg_d.translation_xyz = cfg_wdata_i[62:0];
        CFG_PRINCIPAL:   cfg_d.principal_point = cfg_wdata_i[23:0];
        CFG_INV_FOCAL:   cfg_d.inverse_focal   = cfg_wdata_i[47:0];
        CFG_MAX_DEPTH:   cfg_d.max_depth       = cfg_wdata_i[15:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dpb_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_item)
  );

  dpb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_item),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  dpb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/dpb_checker.sv
`timescale 1ns / 1ps
`include "depth_pixel_backprojection_assert.svh"

module dpb_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_o,
  input  dpb_pkg::pix_t                    in_data_i,
  input  logic                             out_valid_o,
  input  logic                             out_stall_i,
  input  dpb_pkg::point_t                  out_data_o
);
  import dpb_pkg::*;

  logic [15:0]       md_q;
  logic [PEND_W-1:0] pend_q;
  logic              kept_acc, out_acc;

  assign kept_acc = in_valid_i && !in_stall_o && (in_data_i.raw_depth != 16'd0)
                 && (in_data_i.raw_depth < md_q);
  assign out_acc  = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_q   <= MAX_DEPTH_RST;
      pend_q <= '0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == CFG_MAX_DEPTH)) begin
        md_q <= cfg_wdata_i[15:0];
      end
      pend_q <= pend_q + PEND_W'(kept_acc) - PEND_W'(out_acc);
    end
  end

  `DPB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  `DPB_ASSERT_NOW(a_no_spurious, out_valid_o, pend_q != '0)
  `DPB_ASSERT_NOW(a_pend_cap, 1'b1, pend_q <= PEND_W'(PEND_MAX))
  `DPB_ASSERT_NOW(a_stall_full, in_stall_o, pend_q >= PEND_W'(QDEPTH))

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (.*);

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dpb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
  localparam int DRAIN_CYCLES = PEND_MAX + BACK_STAGES + 4;
  localparam int LONG_HOLD    = 200;

  localparam pix_t DIRECTED_PIX [18] = '{
    {12'd0,    12'd0,    16'd1},
    {12'd4095, 12'd4095, 16'd1},
    {12'd325,  12'd253,  16'd1000},
    {12'd326,  12'd254,  16'd1000},
    {12'd0,    12'd0,    16'd6999},
    {12'd4095, 12'd0,    16'd6999},
    {12'd0,    12'd4095, 16'd6999},
    {12'd4095, 12'd4095, 16'd6999},
    {12'd100,  12'd100,  16'd0},
    {12'd100,  12'd100,  16'd7000},
    {12'd100,  12'd100,  16'd7001},
    {12'd100,  12'd100,  16'd65535},
    {12'd639,  12'd479,  16'd4000},
    {12'd2048, 12'd2048, 16'd5000},
    {12'd1,    12'd1,    16'd2},
    {12'd320,  12'd240,  16'd500},
    {12'hAAA,  12'h555,  16'h1234},
    {12'h555,  12'hAAA,  16'h1B57}
  };

  class world_point_board;
    cfg_t   cfg;
    point_t points_due[$];
    int     checked;
    int     dropped;
    int     errors;

    function new();
      cfg     = CFG_RST;
      checked = 0;
      dropped = 0;
      errors  = 0;
    endfunction

    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ROT_X:       cfg.rot_row_x       = data[53:0];
        CFG_ROT_Y:       cfg.rot_row_y       = data[53:0];
        CFG_ROT_Z:       cfg.rot_row_z       = data[53:0];
        CFG_TRANSLATION: cfg.translation_xyz = data[62:0];
        CFG_PRINCIPAL:   cfg.principal_point = data[23:0];
        CFG_INV_FOCAL:   cfg.inverse_focal   = data[47:0];
        CFG_MAX_DEPTH:   cfg.max_depth       = data[15:0];
        default: ;
      endcase
    endfunction

    function longint round_half_up(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint rot_coef(logic [53:0] row, int lo);
      return longint'($signed(row[lo +: 18]));
    endfunction

    function logic signed [23:0] sat24(longint v);
      if (v > 8388607) return 24'sh7FFFFF;
      if (v < -8388608) return 24'sh800000;
      return v[23:0];
    endfunction

    function longint rotate_row(logic [53:0] row, longint px, longint py, longint pz);
      return round_half_up(rot_coef(row, 36) * px + rot_coef(row, 18) * py
                           + rot_coef(row, 0) * pz, 24);
    endfunction

    function point_t backproject(pix_t p);
      point_t w;
      longint d, cx2, cy2, ifx, ify, camx, camy, camz;
      d    = longint'(p.raw_depth);
      cx2  = longint'(cfg.principal_point[23:12]);
      cy2  = longint'(cfg.principal_point[11:0]);
      ifx  = longint'(cfg.inverse_focal[47:24]);
      ify  = longint'(cfg.inverse_focal[23:0]);
      camx = round_half_up((2 * longint'(p.pixel_col) - cx2) * d * ifx, 17);
      camy = round_half_up((2 * longint'(p.pixel_row) - cy2) * d * ify, 17);
      camz = d * 256;
      w.world_x = sat24(rotate_row(cfg.rot_row_x, camx, camy, camz)
                        + longint'($signed(cfg.translation_xyz[62:42])));
      w.world_y = sat24(rotate_row(cfg.rot_row_y, camx, camy, camz)
                        + longint'($signed(cfg.translation_xyz[41:21])));
      w.world_z = sat24(rotate_row(cfg.rot_row_z, camx, camy, camz)
                        + longint'($signed(cfg.translation_xyz[20:0])));
      return w;
    endfunction

    function void note_pixel(pix_t p);
      if (p.raw_depth == 16'd0 || p.raw_depth >= cfg.max_depth) dropped++;
      else points_due = {points_due, backproject(p)};
    endfunction

    function void check_field(string name, logic signed [23:0] want,
                              logic signed [23:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (points_due.size() == 0) begin
        $error("unexpected point x=%0d y=%0d z=%0d", got.world_x, got.world_y, got.world_z);
        errors++;
        return;
      end
      want = points_due.pop_front();
      checked++;
      check_field("world_x", want.world_x, got.world_x);
      check_field("world_y", want.world_y, got.world_y);
      check_field("world_z", want.world_z, got.world_z);
    endfunction

    function int pending();
      return points_due.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  pix_t                  in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  point_t                out_data;

  logic quiet    = 1'b0;
  logic hold_req = 1'b0;
  bit   hold_done;

  world_point_board sb;
  int pixels_sent;
  int settings;
  int burst_left;

  depth_pixel_backprojection u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_n && in_valid && !in_stall) sb.note_pixel(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_point(out_data);
  end

  // receiver: segments of free flow, random stall, and long hold-offs
  initial begin : receiver
    int seg, pct, hold_cnt;
    hold_cnt  = 0;
    hold_done = 1'b0;
    forever begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin pct = 0;   seg = $urandom_range(10, 60); end
        9:       begin pct = 100; seg = $urandom_range(80, 150); end
        default: begin pct = $urandom_range(10, 70); seg = $urandom_range(10, 60); end
      endcase
      for (int i = 0; i < seg; i++) begin
        @(posedge clk_i);
        if (quiet) begin
          out_stall <= 1'b0;
        end else if (hold_req && !hold_done) begin
          out_stall <= 1'b1;
          hold_cnt++;
          if (hold_cnt >= LONG_HOLD) hold_done = 1'b1;
        end else begin
          out_stall <= ($urandom_range(1, 100) <= pct);
        end
      end
    end
  end

  initial begin
    #2000000;
    $error("timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_pixel(pix_t p);
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk_i); while (in_stall);
    pixels_sent++;
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 20);
    end
  endtask

  function automatic pix_t rand_pixel(logic [15:0] lim);
    pix_t p;
    p.pixel_col = $urandom_range(0, 1) ? 12'($urandom_range(0, 639)) : 12'($urandom);
    p.pixel_row = $urandom_range(0, 1) ? 12'($urandom_range(0, 479)) : 12'($urandom);
    case ($urandom_range(0, 15))
      0: p.raw_depth = 16'd0;
      1: p.raw_depth = lim;
      2: p.raw_depth = lim - 16'd1;
      3, 4, 5, 6, 7, 8, 9:
        p.raw_depth = (lim > 16'd1) ? 16'($urandom_range(1, lim - 1)) : 16'd1;
      default: p.raw_depth = 16'($urandom);
    endcase
    return p;
  endfunction

  task automatic run_pixels(int n, bit steady);
    for (int i = 0; i < n; i++) begin
      send_pixel(rand_pixel(sb.cfg.max_depth));
      if (!steady) pace();
    end
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    quiet <= 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value,
                           int width);
    logic [63:0]           junk;
    logic [CFG_DATA_W-1:0] data;
    junk      = {$urandom, $urandom};
    data      = (junk[CFG_DATA_W-1:0] << width) | value;
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    sb.apply_write(idx, data);
  endtask

  task automatic load_config(cfg_t c);
    drain_pipeline();
    write_reg(CFG_IDX_SPARE, {$urandom, $urandom}, 63);
    write_reg(CFG_ROT_X, c.rot_row_x, 54);
    write_reg(CFG_ROT_Y, c.rot_row_y, 54);
    write_reg(CFG_ROT_Z, c.rot_row_z, 54);
    write_reg(CFG_TRANSLATION, c.translation_xyz, 63);
    write_reg(CFG_PRINCIPAL, c.principal_point, 24);
    write_reg(CFG_INV_FOCAL, c.inverse_focal, 48);
    write_reg(CFG_MAX_DEPTH, c.max_depth, 16);
    cfg_we <= 1'b0;
    quiet  <= 1'b0;
    settings++;
  endtask

  function automatic logic [17:0] rot_field(bit wild);
    if (wild) return 18'($urandom);
    return 18'($urandom_range(0, 131072)) - 18'd65536;
  endfunction

  function automatic logic [20:0] trans_field();
    if ($urandom_range(0, 3) == 0) return 21'($urandom);
    return 21'($urandom_range(0, 8192)) - 21'd4096;
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    bit   wild_rot, wild_cam;
    wild_rot = ($urandom_range(0, 2) == 0);
    wild_cam = ($urandom_range(0, 2) == 0);
    c.rot_row_x = {rot_field(wild_rot), rot_field(wild_rot), rot_field(wild_rot)};
    c.rot_row_y = {rot_field(wild_rot), rot_field(wild_rot), rot_field(wild_rot)};
    c.rot_row_z = {rot_field(wild_rot), rot_field(wild_rot), rot_field(wild_rot)};
    c.translation_xyz = {trans_field(), trans_field(), trans_field()};
    if (wild_cam) begin
      c.principal_point = 24'($urandom);
      c.inverse_focal   = {24'($urandom), 24'($urandom)};
    end else begin
      c.principal_point = {12'($urandom_range(560, 740)), 12'($urandom_range(420, 590))};
      c.inverse_focal   = {24'($urandom_range(25000, 45000)),
                           24'($urandom_range(25000, 45000))};
    end
    case ($urandom_range(0, 3))
      0:       c.max_depth = 16'hFFFF;
      1:       c.max_depth = 16'($urandom);
      default: c.max_depth = 16'($urandom_range(1, 10000));
    endcase
    return c;
  endfunction

  initial begin : stimulus
    cfg_t c;
    sb          = new();
    pixels_sent = 0;
    settings    = 1;
    burst_left  = 0;
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (DIRECTED_PIX[i]) begin
      send_pixel(DIRECTED_PIX[i]);
      pace();
    end

    // max_depth of zero drops everything
    c = CFG_RST;
    c.max_depth = 16'd0;
    load_config(c);
    run_pixels(15, 1'b0);

    // positive saturation
    c.rot_row_x       = {3{18'h1FFFF}};
    c.rot_row_y       = {3{18'h1FFFF}};
    c.rot_row_z       = {3{18'h1FFFF}};
    c.translation_xyz = {3{21'h0FFFFF}};
    c.principal_point = 24'h000000;
    c.inverse_focal   = 48'hFFFFFF_FFFFFF;
    c.max_depth       = 16'hFFFF;
    load_config(c);
    run_pixels(20, 1'b0);

    // negative saturation
    c.rot_row_x       = {3{18'h20000}};
    c.rot_row_y       = {3{18'h20000}};
    c.rot_row_z       = {3{18'h20000}};
    c.translation_xyz = {3{21'h100000}};
    c.principal_point = 24'hFFFFFF;
    load_config(c);
    run_pixels(20, 1'b0);

    // zero rotation and focal: translation only
    c.rot_row_x       = '0;
    c.rot_row_y       = '0;
    c.rot_row_z       = '0;
    c.translation_xyz = {trans_field(), trans_field(), trans_field()};
    c.principal_point = 24'($urandom);
    c.inverse_focal   = '0;
    load_config(c);
    run_pixels(10, 1'b0);

    repeat (4) begin
      load_config(rand_cfg());
      run_pixels($urandom_range(35, 55), 1'b0);
    end

    // back-to-back items against a long output hold-off
    c = CFG_RST;
    c.max_depth = 16'hFFFF;
    load_config(c);
    hold_req <= 1'b1;
    run_pixels(40, 1'b1);
    hold_req <= 1'b0;

    repeat (4) begin
      load_config(rand_cfg());
      run_pixels($urandom_range(35, 55), 1'b0);
    end

    drain_pipeline();
    $display("Ran %0d pixels under %0d register settings, incl. drops and saturation",
             pixels_sent, settings);
    $display("%0d points checked, %0d pixels dropped", sb.checked, sb.dropped);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
